// ===== design/photometric_normal_solver_defines.svh =====
// Assertion macros for the photometric normal solver RTL.
// No dependencies; include by bare file name.
`ifndef PHOTOMETRIC_NORMAL_SOLVER_DEFINES_SVH
`define PHOTOMETRIC_NORMAL_SOLVER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PNS_ASSERT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define PNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pns_pkg.sv =====
// Types, codes and helpers for the photometric normal solver.
// No dependencies.
`default_nettype none

package pns_pkg;

  localparam int unsigned GramLim = 19;
  localparam int unsigned VecLim  = 30;
  localparam int unsigned LastPc  = 23;

  typedef logic signed [63:0] wide_t;

  // one pixel's sums, handed from the front to the back
  typedef struct packed {
    logic             bg;
    logic [5:0][35:0] gram;
    logic [2:0][36:0] proj;
  } pns_job_t;

  typedef enum logic [1:0] {
    ST_OK, ST_BACKGROUND, ST_ZERO_LEN, ST_SINGULAR
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE, F_ROOT, F_ACC, F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE, B_NORM_IN, B_PROG, B_MAC, B_VCHK, B_NORM_V, B_SQ, B_ROOT,
    B_DIV_LOAD, B_DIV, B_DONE
  } back_state_e;

  typedef enum logic [3:0] {
    OP_GA, OP_GB, OP_GC, OP_GD, OP_GE, OP_GF, OP_P0, OP_P1, OP_P2,
    OP_C00, OP_C01, OP_C02, OP_C11, OP_C12, OP_C22
  } opnd_e;

  typedef enum logic [3:0] {
    D_NONE, D_C00, D_C01, D_C02, D_C11, D_C12, D_C22, D_DET, D_V0, D_V1, D_V2
  } dest_e;

  typedef struct packed {
    opnd_e x;
    opnd_e y;
    logic  neg;
    logic  first;
    dest_e dest;
  } step_t;

  // product program: cofactors, determinant, then adj(G)*p
  function automatic step_t prog_step(logic [4:0] pc);
    step_t s;
    case (pc)
      5'd0:  s = '{OP_GD,  OP_GF, 1'b0, 1'b1, D_NONE};
      5'd1:  s = '{OP_GE,  OP_GE, 1'b1, 1'b0, D_C00};
      5'd2:  s = '{OP_GC,  OP_GE, 1'b0, 1'b1, D_NONE};
      5'd3:  s = '{OP_GB,  OP_GF, 1'b1, 1'b0, D_C01};
      5'd4:  s = '{OP_GB,  OP_GE, 1'b0, 1'b1, D_NONE};
      5'd5:  s = '{OP_GC,  OP_GD, 1'b1, 1'b0, D_C02};
      5'd6:  s = '{OP_GA,  OP_GF, 1'b0, 1'b1, D_NONE};
      5'd7:  s = '{OP_GC,  OP_GC, 1'b1, 1'b0, D_C11};
      5'd8:  s = '{OP_GB,  OP_GC, 1'b0, 1'b1, D_NONE};
      5'd9:  s = '{OP_GA,  OP_GE, 1'b1, 1'b0, D_C12};
      5'd10: s = '{OP_GA,  OP_GD, 1'b0, 1'b1, D_NONE};
      5'd11: s = '{OP_GB,  OP_GB, 1'b1, 1'b0, D_C22};
      5'd12: s = '{OP_C00, OP_GA, 1'b0, 1'b1, D_NONE};
      5'd13: s = '{OP_C01, OP_GB, 1'b0, 1'b0, D_NONE};
      5'd14: s = '{OP_C02, OP_GC, 1'b0, 1'b0, D_DET};
      5'd15: s = '{OP_C00, OP_P0, 1'b0, 1'b1, D_NONE};
      5'd16: s = '{OP_C01, OP_P1, 1'b0, 1'b0, D_NONE};
      5'd17: s = '{OP_C02, OP_P2, 1'b0, 1'b0, D_V0};
      5'd18: s = '{OP_C01, OP_P0, 1'b0, 1'b1, D_NONE};
      5'd19: s = '{OP_C11, OP_P1, 1'b0, 1'b0, D_NONE};
      5'd20: s = '{OP_C12, OP_P2, 1'b0, 1'b0, D_V1};
      5'd21: s = '{OP_C02, OP_P0, 1'b0, 1'b1, D_NONE};
      5'd22: s = '{OP_C12, OP_P1, 1'b0, 1'b0, D_NONE};
      5'd23: s = '{OP_C22, OP_P2, 1'b0, 1'b0, D_V2};
      default: s = '{OP_GA, OP_GA, 1'b0, 1'b1, D_NONE};
    endcase
    return s;
  endfunction

  function automatic logic [63:0] mag(wide_t x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  // halve the magnitude, keep the sign (truncation toward zero)
  function automatic wide_t half_mag(wide_t x);
    logic [63:0] m;
    m = mag(x) >> 1;
    return x[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage

`default_nettype wire

// ===== design/pns_queue.sv =====
// Two-entry queue of pixel jobs between the front and the back.
// Depends on pns_pkg and photometric_normal_solver_defines.svh.
`default_nettype none
`include "photometric_normal_solver_defines.svh"

module pns_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  pns_pkg::pns_job_t    push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output pns_pkg::pns_job_t    pop_data_o,
  output logic                 empty_o
);

  pns_pkg::pns_job_t entry_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        level_q;

  assign full_o     = (level_q == 2'd2);
  assign empty_o    = (level_q == 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];

  // store pushed job
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // advance pointers and level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      level_q <= level_q + 2'd1;
      else if (pop_i && !push_i) level_q <= level_q - 2'd1;
    end
  end

  `PNS_ASSERT(a_no_overflow, clk_i, rst_ni, push_i, !full_o, "push into full queue")
  `PNS_ASSERT(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o, "pop from empty queue")
  `PNS_ASSERT_NEXT(a_push_kept, clk_i, rst_ni, push_i && !pop_i, !empty_o, "pushed job lost")

endmodule

`default_nettype wire

// ===== design/pns_front.sv =====
// Front end: takes light beats, forms the intensity and accumulates the sums.
// Depends on pns_pkg; feeds pns_queue.
`default_nettype none

module pns_front #(
  parameter int unsigned MAX_LIGHTS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               background_i,
  input  wire logic [7:0]         red_i,
  input  wire logic [7:0]         green_i,
  input  wire logic [7:0]         blue_i,
  input  wire logic signed [15:0] light_x_i,
  input  wire logic signed [15:0] light_y_i,
  input  wire logic signed [15:0] light_z_i,
  input  wire logic               last_light_i,
  output logic                    push_o,
  output pns_pkg::pns_job_t       job_o,
  input  wire logic               full_i
);

  localparam int unsigned CntW = $clog2(MAX_LIGHTS + 1);

  pns_pkg::front_state_e state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic signed [35:0]  gram_q [6];
  logic signed [35:0]  gram_d [6];
  logic signed [36:0]  proj_q [3];
  logic signed [36:0]  proj_d [3];
  logic                bg_q, bg_d, last_q, last_d;
  logic signed [15:0]  l_q [3];
  logic signed [15:0]  l_d [3];
  logic [31:0]         rx_q, rx_d, rr_q, rr_d, rb_q, rb_d;
  logic                accept;
  logic [17:0]         sumsq;
  logic signed [31:0]  gprod [6];
  logic signed [32:0]  pprod [3];
  logic signed [36:0]  gsum [6];
  logic signed [37:0]  psum [3];
  logic signed [16:0]  t_s;

  assign in_stall_o = (state_q != pns_pkg::F_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign sumsq      = 18'(red_i) * 18'(red_i) + 18'(green_i) * 18'(green_i)
                      + 18'(blue_i) * 18'(blue_i);
  assign t_s        = $signed({1'b0, rr_q[15:0]});

  // form products and widened sums
  always_comb begin
    gprod[0] = l_q[0] * l_q[0];
    gprod[1] = l_q[0] * l_q[1];
    gprod[2] = l_q[0] * l_q[2];
    gprod[3] = l_q[1] * l_q[1];
    gprod[4] = l_q[1] * l_q[2];
    gprod[5] = l_q[2] * l_q[2];
    for (int k = 0; k < 6; k++) begin
      gsum[k] = 37'(gprod[k]) + 37'(gram_q[k]);
    end
    for (int k = 0; k < 3; k++) begin
      pprod[k] = l_q[k] * t_s;
      psum[k]  = 38'(pprod[k]) + 38'(proj_q[k]);
    end
  end

  // pack job for the back end
  always_comb begin
    job_o.bg = bg_q;
    for (int k = 0; k < 6; k++) job_o.gram[k] = gram_q[k];
    for (int k = 0; k < 3; k++) job_o.proj[k] = proj_q[k];
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    gram_d  = gram_q;
    proj_d  = proj_q;
    bg_d    = bg_q;
    last_d  = last_q;
    l_d     = l_q;
    rx_d    = rx_q;
    rr_d    = rr_q;
    rb_d    = rb_q;
    push_o  = 1'b0;
    case (state_q)
      pns_pkg::F_IDLE: begin
        if (accept) begin
          bg_d   = background_i;
          last_d = last_light_i;
          l_d[0] = light_x_i;
          l_d[1] = light_y_i;
          l_d[2] = light_z_i;
          rx_d   = {sumsq, 14'b0};
          rr_d   = '0;
          rb_d   = 32'h4000_0000;
          if (!background_i && (cnt_q < CntW'(MAX_LIGHTS))) begin
            state_d = pns_pkg::F_ROOT;
          end else if (last_light_i) begin
            state_d = pns_pkg::F_PUSH;
          end
        end
      end
      pns_pkg::F_ROOT: begin
        // one result bit per cycle
        if (rb_q == '0) begin
          state_d = pns_pkg::F_ACC;
        end else begin
          if (rx_q >= rr_q + rb_q) begin
            rx_d = rx_q - (rr_q + rb_q);
            rr_d = (rr_q >> 1) + rb_q;
          end else begin
            rr_d = rr_q >> 1;
          end
          rb_d = rb_q >> 2;
        end
      end
      pns_pkg::F_ACC: begin
        for (int k = 0; k < 6; k++) begin
          if (gsum[k][36] != gsum[k][35]) gram_d[k] = {gsum[k][36], {35{~gsum[k][36]}}};
          else gram_d[k] = gsum[k][35:0];
        end
        for (int k = 0; k < 3; k++) begin
          if (psum[k][37] != psum[k][36]) proj_d[k] = {psum[k][37], {36{~psum[k][37]}}};
          else proj_d[k] = psum[k][36:0];
        end
        cnt_d   = cnt_q + 1'b1;
        state_d = last_q ? pns_pkg::F_PUSH : pns_pkg::F_IDLE;
      end
      pns_pkg::F_PUSH: begin
        // hand over and clear for next pixel
        if (!full_i) begin
          push_o  = 1'b1;
          cnt_d   = '0;
          for (int k = 0; k < 6; k++) gram_d[k] = '0;
          for (int k = 0; k < 3; k++) proj_d[k] = '0;
          state_d = pns_pkg::F_IDLE;
        end
      end
      default: state_d = pns_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pns_pkg::F_IDLE;
      cnt_q   <= '0;
      for (int k = 0; k < 6; k++) gram_q[k] <= '0;
      for (int k = 0; k < 3; k++) proj_q[k] <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      gram_q  <= gram_d;
      proj_q  <= proj_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    bg_q   <= bg_d;
    last_q <= last_d;
    l_q    <= l_d;
    rx_q   <= rx_d;
    rr_q   <= rr_d;
    rb_q   <= rb_d;
  end

endmodule

`default_nettype wire

// ===== design/pns_back.sv =====
// Back end: solves the normal equations with a serial multiply-accumulate,
// root and divider, and holds the result beat. Depends on pns_pkg.
`default_nettype none

module pns_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  pns_pkg::pns_job_t job_i,
  input  wire logic         empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [15:0]       normal_x_o,
  output logic [15:0]       normal_y_o,
  output logic [15:0]       normal_z_o,
  output logic [7:0]        map_red_o,
  output logic [7:0]        map_green_o,
  output logic [7:0]        map_blue_o,
  output logic [1:0]        status_o
);

  pns_pkg::back_state_e state_q, state_d;
  pns_pkg::wide_t g_q [6];
  pns_pkg::wide_t g_d [6];
  pns_pkg::wide_t p_q [3];
  pns_pkg::wide_t p_d [3];
  pns_pkg::wide_t c_q [6];
  pns_pkg::wide_t c_d [6];
  pns_pkg::wide_t v_q [3];
  pns_pkg::wide_t v_d [3];
  pns_pkg::wide_t det_q, det_d, acc_q, acc_d;
  logic [63:0]    macx_q, macx_d, macy_q, macy_d;
  logic           msub_q, msub_d, sq_q, sq_d;
  logic [4:0]     pc_q, pc_d;
  logic [1:0]     idx_q, idx_d;
  logic [63:0]    rx_q, rx_d, rr_q, rr_d, rb_q, rb_d;
  logic [31:0]    len_q, len_d;
  logic [63:0]    num_q, num_d, trial;
  logic [15:0]    quo_q, quo_d, qcl;
  logic [3:0]     bit_q, bit_d;
  logic signed [15:0] n_q [3];
  logic signed [15:0] n_d [3];
  pns_pkg::status_e   st_q, st_d;
  logic           out_valid_q, out_valid_d, load_out;
  logic [15:0]    onx_q, ony_q, onz_q;
  logic [7:0]     omr_q, omg_q, omb_q;
  pns_pkg::status_e ost_q;
  logic [14:0][63:0] ops;
  pns_pkg::step_t step;
  pns_pkg::wide_t xs, ys;
  logic           big_g, big_p, big_v, vzero;

  function automatic logic [7:0] map8(logic signed [15:0] n);
    logic [23:0] s;
    s = ({8'b0, n} << 8) - {8'b0, n};
    return n > 0 ? s[21:14] : 8'd0;
  endfunction

  // operand selection for the product program
  always_comb begin
    for (int k = 0; k < 6; k++) ops[k] = g_q[k];
    for (int k = 0; k < 3; k++) ops[6 + k] = p_q[k];
    for (int k = 0; k < 6; k++) ops[9 + k] = c_q[k];
    step = pns_pkg::prog_step(pc_q);
    xs   = $signed(ops[step.x]);
    ys   = $signed(ops[step.y]);
  end

  // range tests for the block shifts
  always_comb begin
    big_g = 1'b0;
    big_p = 1'b0;
    big_v = 1'b0;
    for (int k = 0; k < 6; k++)
      if ((pns_pkg::mag(g_q[k]) >> pns_pkg::GramLim) != '0) big_g = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if ((pns_pkg::mag(p_q[k]) >> pns_pkg::GramLim) != '0) big_p = 1'b1;
      if ((pns_pkg::mag(v_q[k]) >> pns_pkg::VecLim) != '0) big_v = 1'b1;
    end
    vzero = (v_q[0] == '0) && (v_q[1] == '0) && (v_q[2] == '0);
    trial = 64'(len_q) << bit_q;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    g_d = g_q; p_d = p_q; c_d = c_q; v_d = v_q; n_d = n_q;
    det_d = det_q; acc_d = acc_q;
    macx_d = macx_q; macy_d = macy_q; msub_d = msub_q; sq_d = sq_q;
    pc_d = pc_q; idx_d = idx_q;
    rx_d = rx_q; rr_d = rr_q; rb_d = rb_q; len_d = len_q;
    num_d = num_q; quo_d = quo_q; bit_d = bit_q; qcl = '0;
    st_d = st_q;
    pop_o = 1'b0;
    load_out = 1'b0;
    case (state_q)
      pns_pkg::B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          for (int k = 0; k < 6; k++) g_d[k] = 64'($signed(job_i.gram[k]));
          for (int k = 0; k < 3; k++) begin
            p_d[k] = 64'($signed(job_i.proj[k]));
            n_d[k] = '0;
          end
          pc_d = '0;
          sq_d = 1'b0;
          if (job_i.bg) begin
            st_d    = pns_pkg::ST_BACKGROUND;
            state_d = pns_pkg::B_DONE;
          end else begin
            state_d = pns_pkg::B_NORM_IN;
          end
        end
      end
      pns_pkg::B_NORM_IN: begin
        // shift gram and projection groups one bit a cycle
        if (big_g) for (int k = 0; k < 6; k++) g_d[k] = pns_pkg::half_mag(g_q[k]);
        if (big_p) for (int k = 0; k < 3; k++) p_d[k] = pns_pkg::half_mag(p_q[k]);
        if (!big_g && !big_p) state_d = pns_pkg::B_PROG;
      end
      pns_pkg::B_PROG: begin
        macx_d  = pns_pkg::mag(xs);
        macy_d  = pns_pkg::mag(ys);
        msub_d  = xs[63] ^ ys[63] ^ step.neg;
        if (step.first) acc_d = '0;
        state_d = pns_pkg::B_MAC;
      end
      pns_pkg::B_MAC: begin
        if (macy_q == '0) begin
          if (sq_q) begin
            if (idx_q == 2'd2) begin
              rx_d    = acc_q;
              rr_d    = '0;
              rb_d    = 64'h4000_0000_0000_0000;
              state_d = pns_pkg::B_ROOT;
            end else begin
              idx_d   = idx_q + 2'd1;
              state_d = pns_pkg::B_SQ;
            end
          end else begin
            case (step.dest)
              pns_pkg::D_C00: c_d[0] = acc_q;
              pns_pkg::D_C01: c_d[1] = acc_q;
              pns_pkg::D_C02: c_d[2] = acc_q;
              pns_pkg::D_C11: c_d[3] = acc_q;
              pns_pkg::D_C12: c_d[4] = acc_q;
              pns_pkg::D_C22: c_d[5] = acc_q;
              pns_pkg::D_DET: det_d  = acc_q;
              pns_pkg::D_V0:  v_d[0] = acc_q;
              pns_pkg::D_V1:  v_d[1] = acc_q;
              pns_pkg::D_V2:  v_d[2] = acc_q;
              default: ;
            endcase
            if ((step.dest == pns_pkg::D_DET) && (acc_q == '0)) begin
              st_d    = pns_pkg::ST_SINGULAR;
              state_d = pns_pkg::B_DONE;
            end else if (pc_q == 5'(pns_pkg::LastPc)) begin
              state_d = pns_pkg::B_VCHK;
            end else begin
              pc_d    = pc_q + 5'd1;
              state_d = pns_pkg::B_PROG;
            end
          end
        end else begin
          // add one partial product
          if (macy_q[0]) acc_d = msub_q ? acc_q - $signed(macx_q) : acc_q + $signed(macx_q);
          macx_d = macx_q << 1;
          macy_d = macy_q >> 1;
        end
      end
      pns_pkg::B_VCHK: begin
        if (vzero) begin
          st_d    = pns_pkg::ST_ZERO_LEN;
          state_d = pns_pkg::B_DONE;
        end else begin
          if (det_q[63]) for (int k = 0; k < 3; k++) v_d[k] = -v_q[k];
          state_d = pns_pkg::B_NORM_V;
        end
      end
      pns_pkg::B_NORM_V: begin
        if (big_v) begin
          for (int k = 0; k < 3; k++) v_d[k] = pns_pkg::half_mag(v_q[k]);
        end else begin
          idx_d   = '0;
          sq_d    = 1'b1;
          state_d = pns_pkg::B_SQ;
        end
      end
      pns_pkg::B_SQ: begin
        macx_d = pns_pkg::mag(v_q[idx_q]);
        macy_d = pns_pkg::mag(v_q[idx_q]);
        msub_d = 1'b0;
        if (idx_q == 2'd0) acc_d = '0;
        state_d = pns_pkg::B_MAC;
      end
      pns_pkg::B_ROOT: begin
        if (rb_q == '0) begin
          len_d = rr_q[31:0];
          idx_d = '0;
          if (rr_q == '0) begin
            st_d    = pns_pkg::ST_ZERO_LEN;
            state_d = pns_pkg::B_DONE;
          end else begin
            state_d = pns_pkg::B_DIV_LOAD;
          end
        end else begin
          if (rx_q >= rr_q + rb_q) begin
            rx_d = rx_q - (rr_q + rb_q);
            rr_d = (rr_q >> 1) + rb_q;
          end else begin
            rr_d = rr_q >> 1;
          end
          rb_d = rb_q >> 2;
        end
      end
      pns_pkg::B_DIV_LOAD: begin
        num_d   = (pns_pkg::mag(v_q[idx_q]) << 14) + 64'(len_q >> 1);
        quo_d   = '0;
        bit_d   = 4'd15;
        state_d = pns_pkg::B_DIV;
      end
      pns_pkg::B_DIV: begin
        // one quotient bit per cycle
        if (num_q >= trial) begin
          num_d        = num_q - trial;
          quo_d[bit_q] = 1'b1;
        end
        if (bit_q == '0) begin
          qcl = (quo_d > 16'd16384) ? 16'd16384 : quo_d;
          n_d[idx_q] = v_q[idx_q][63] ? -$signed(qcl) : $signed(qcl);
          if (idx_q == 2'd2) begin
            st_d    = pns_pkg::ST_OK;
            state_d = pns_pkg::B_DONE;
          end else begin
            idx_d   = idx_q + 2'd1;
            state_d = pns_pkg::B_DIV_LOAD;
          end
        end else begin
          bit_d = bit_q - 4'd1;
        end
      end
      pns_pkg::B_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = pns_pkg::B_IDLE;
        end
      end
      default: state_d = pns_pkg::B_IDLE;
    endcase
  end

  // result beat register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pns_pkg::B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    g_q <= g_d; p_q <= p_d; c_q <= c_d; v_q <= v_d; n_q <= n_d;
    det_q <= det_d; acc_q <= acc_d;
    macx_q <= macx_d; macy_q <= macy_d; msub_q <= msub_d; sq_q <= sq_d;
    pc_q <= pc_d; idx_q <= idx_d;
    rx_q <= rx_d; rr_q <= rr_d; rb_q <= rb_d; len_q <= len_d;
    num_q <= num_d; quo_q <= quo_d; bit_q <= bit_d;
    st_q <= st_d;
    if (load_out) begin
      onx_q <= (st_q == pns_pkg::ST_OK) ? n_q[0] : '0;
      ony_q <= (st_q == pns_pkg::ST_OK) ? n_q[1] : '0;
      onz_q <= (st_q == pns_pkg::ST_OK) ? n_q[2] : '0;
      omr_q <= (st_q == pns_pkg::ST_OK) ? map8(n_q[0]) : '0;
      omg_q <= (st_q == pns_pkg::ST_OK) ? map8(n_q[1]) : '0;
      omb_q <= (st_q == pns_pkg::ST_OK) ? map8(n_q[2]) : '0;
      ost_q <= st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign normal_x_o  = onx_q;
  assign normal_y_o  = ony_q;
  assign normal_z_o  = onz_q;
  assign map_red_o   = omr_q;
  assign map_green_o = omg_q;
  assign map_blue_o  = omb_q;
  assign status_o    = ost_q;

endmodule

`default_nettype wire

// ===== design/photometric_normal_solver.sv =====
// Top level of the photometric normal solver: front, job queue, back.
// Depends on pns_pkg, pns_front, pns_queue, pns_back.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------------
//  in      | in_valid_i / in_stall_o | background, red/green/blue, light_x/y/z,
//          |                         | last_light
//  out     | out_valid_o/out_stall_i | normal_x/y/z, map_red/green/blue, status
//
// An accumulated beat stalls the input after it is taken, through the root steps and
// one sum update; a background or over-count beat stalls it only when it is last. A
// last beat also holds the stall until its job is handed to the two-entry queue.
// The solve runs in the back end: 24 serial products, block shifts of the inputs and
// of the vector, three squares, a root and three divisions.
// Reset clears the front-end sums; a stalled result holds while the back end works on.
`default_nettype none

module photometric_normal_solver #(
  parameter int unsigned MAX_LIGHTS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               background_i,
  input  wire logic [7:0]         red_i,
  input  wire logic [7:0]         green_i,
  input  wire logic [7:0]         blue_i,
  input  wire logic signed [15:0] light_x_i,
  input  wire logic signed [15:0] light_y_i,
  input  wire logic signed [15:0] light_z_i,
  input  wire logic               last_light_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      normal_x_o,
  output logic signed [15:0]      normal_y_o,
  output logic signed [15:0]      normal_z_o,
  output logic [7:0]              map_red_o,
  output logic [7:0]              map_green_o,
  output logic [7:0]              map_blue_o,
  output logic [1:0]              status_o
);

  pns_pkg::pns_job_t push_job, pop_job;
  logic              push, pop, full, empty;
  logic [15:0]       nx, ny, nz;

  pns_front #(.MAX_LIGHTS(MAX_LIGHTS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .background_i, .red_i, .green_i, .blue_i,
    .light_x_i, .light_y_i, .light_z_i, .last_light_i,
    .push_o (push), .job_o (push_job), .full_i (full)
  );

  pns_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (push), .push_data_i (push_job), .full_o (full),
    .pop_i (pop), .pop_data_o (pop_job), .empty_o (empty)
  );

  pns_back u_back (
    .clk_i, .rst_ni,
    .job_i (pop_job), .empty_i (empty), .pop_o (pop),
    .out_valid_o, .out_stall_i,
    .normal_x_o (nx), .normal_y_o (ny), .normal_z_o (nz),
    .map_red_o, .map_green_o, .map_blue_o, .status_o
  );

  assign normal_x_o = $signed(nx);
  assign normal_y_o = $signed(ny);
  assign normal_z_o = $signed(nz);

endmodule

`default_nettype wire
